[design/lrq_pkg.sv]
package lrq_pkg;

  // payload field widths
  localparam int OP_W    = 2;
  localparam int ID_W    = 6;
  localparam int ST_W    = 2;
  localparam int LIMIT_W = 7;

  // APB register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register indexes (word address)
  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

endpackage

[design/lrq_if.sv]
// request channel: operation on one entry
interface lrq_req_if;
  logic                      valid;
  logic                      ready;
  logic [lrq_pkg::OP_W-1:0]  operation;
  logic [lrq_pkg::ID_W-1:0]  entry_id;

  modport source (output valid, output operation, output entry_id, input ready);
  modport sink   (input valid, input operation, input entry_id, output ready);
endinterface

// result channel: one transfer per eviction, or one per request
interface lrq_res_if;
  logic                      valid;
  logic                      ready;
  logic [lrq_pkg::ID_W-1:0]  evicted_id;
  logic                      evict_valid;
  logic [lrq_pkg::ST_W-1:0]  status;
  logic                      last;

  modport source (output valid, output evicted_id, output evict_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input evicted_id, input evict_valid, input status,
                  input last, output ready);
endinterface

[design/lrq_ram.sv]
// single write port, single read port, registered read
module lrq_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/lrq_apb_regs.sv]
// capacity limit register behind an APB slave
module lrq_apb_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lrq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lrq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lrq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [lrq_pkg::LIMIT_W-1:0]        capacity_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write; other addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= lrq_pkg::LIMIT_RESET;
    end else if (wr_en && (paddr[2] == lrq_pkg::REG_CAPACITY_LIMIT)) begin
      capacity_limit <= pwdata[lrq_pkg::LIMIT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == lrq_pkg::REG_CAPACITY_LIMIT) begin
      prdata = lrq_pkg::APB_DATA_W'(capacity_limit);
    end
  end

endmodule

[design/lru_replacement_queue.sv]
// LRU order of up to ENTRIES slots, kept as a doubly linked list in two link RAMs.
// Each request first reads both link RAMs and is then decided; touch and insert append the
// entry in two write steps, and an insert then checks for eviction, reading and unlinking
// one oldest entry per eviction. Each result is loaded into the result register once free.
// A new request is taken only in the idle state, once the final result of the request in
// hand has been loaded, so a stalled result channel also holds back the request channel.
module lru_replacement_queue #(
  parameter int ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  lrq_req_if.sink                         req,
  lrq_res_if.source                       res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lrq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lrq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_APP_A, S_APP_B, S_EV_RD, S_EV_WR, S_EMIT
  } state_t;

  typedef struct packed {
    logic [lrq_pkg::ID_W-1:0] id;
    logic                     evict;
    logic [lrq_pkg::ST_W-1:0] status;
    logic                     last;
  } result_t;

  state_t                       state;
  logic [lrq_pkg::LIMIT_W-1:0]  capacity_limit;

  logic [ENTRIES-1:0]           present;
  logic [LW-1:0]                oldest;
  logic [LW-1:0]                newest;
  logic [LW-1:0]                entry_count;

  logic [lrq_pkg::OP_W-1:0]     op_q;
  logic [IW-1:0]                idx_q;
  logic                         inr_q;
  logic                         hit_q;
  logic [IW-1:0]                victim;
  result_t                      pend;

  logic                         res_valid;
  result_t                      res_q;

  // link RAM ports
  logic            nxt_we, nxt_re, prv_we, prv_re;
  logic [IW-1:0]   nxt_waddr, nxt_raddr, prv_waddr, prv_raddr;
  logic [LW-1:0]   nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

  logic            req_fire;
  logic [IW-1:0]   req_idx;
  logic            req_inr;
  logic            out_free;
  logic            evict_cond;
  logic [LW-1:0]   count_dec;
  logic            last_calc;
  logic [LW-1:0]   idx_link;

  lrq_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .capacity_limit (capacity_limit)
  );

  lrq_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (nxt_re),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  lrq_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (prv_re),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  assign req.ready = (state == S_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;
  assign req_idx   = IW'(req.entry_id);
  assign req_inr   = ({1'b0, req.entry_id} < (lrq_pkg::ID_W + 1)'(ENTRIES));
  assign out_free  = !res_valid || res.ready;
  assign idx_link  = LW'(idx_q);

  // eviction test and lookahead for the last flag
  assign evict_cond = (lrq_pkg::LIMIT_W'(entry_count) > capacity_limit) && (oldest < NULL_LINK);
  assign count_dec  = entry_count - LW'(1);
  assign last_calc  = !((lrq_pkg::LIMIT_W'(count_dec) > capacity_limit) &&
                        (nxt_rdata < NULL_LINK));

  assign res.valid       = res_valid;
  assign res.evicted_id  = res_q.id;
  assign res.evict_valid = res_q.evict;
  assign res.status      = res_q.status;
  assign res.last        = res_q.last;

  // link RAM reads and writes per state
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = '0;
    nxt_wdata = NULL_LINK;
    nxt_re    = 1'b0;
    nxt_raddr = req_idx;
    prv_we    = 1'b0;
    prv_waddr = '0;
    prv_wdata = NULL_LINK;
    prv_re    = 1'b0;
    prv_raddr = req_idx;
    case (state)
      S_IDLE: begin
        nxt_re = req_fire;
        prv_re = req_fire;
      end
      S_DECIDE: begin
        // unlink a present entry: prev.next = next, next.prev = prev
        if ((op_q inside {lrq_pkg::OP_TOUCH, lrq_pkg::OP_ERASE}) && hit_q) begin
          nxt_we    = (prv_rdata < NULL_LINK);
          nxt_waddr = prv_rdata[IW-1:0];
          nxt_wdata = nxt_rdata;
          prv_we    = (nxt_rdata < NULL_LINK);
          prv_waddr = nxt_rdata[IW-1:0];
          prv_wdata = prv_rdata;
        end
      end
      S_APP_A: begin
        nxt_we    = 1'b1;
        nxt_waddr = idx_q;
        nxt_wdata = NULL_LINK;
        prv_we    = 1'b1;
        prv_waddr = idx_q;
        prv_wdata = newest;
      end
      S_APP_B: begin
        nxt_we    = (newest < NULL_LINK);
        nxt_waddr = newest[IW-1:0];
        nxt_wdata = idx_link;
      end
      S_EV_RD: begin
        nxt_re    = evict_cond;
        nxt_raddr = oldest[IW-1:0];
      end
      S_EV_WR: begin
        // the new oldest entry loses its back link
        prv_we    = (nxt_rdata < NULL_LINK);
        prv_waddr = nxt_rdata[IW-1:0];
        prv_wdata = NULL_LINK;
      end
      default: begin
      end
    endcase
  end

  // sequencer, list head/tail, presence bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      present     <= '0;
      oldest      <= NULL_LINK;
      newest      <= NULL_LINK;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      // result register empties on a transfer unless it reloads below
      if (res.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            op_q  <= req.operation;
            idx_q <= req_idx;
            inr_q <= req_inr;
            hit_q <= req_inr && present[req_idx];
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (op_q)
            lrq_pkg::OP_INSERT: begin
              if (!inr_q) begin
                pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_ABSENT, last: 1'b1};
                state <= S_EMIT;
              end else if (hit_q) begin
                pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_DUP, last: 1'b1};
                state <= S_EMIT;
              end else begin
                present[idx_q] <= 1'b1;
                entry_count    <= entry_count + LW'(1);
                state          <= S_APP_A;
              end
            end
            lrq_pkg::OP_TOUCH, lrq_pkg::OP_ERASE: begin
              if (!hit_q) begin
                pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_ABSENT, last: 1'b1};
                state <= S_EMIT;
              end else begin
                if (!(prv_rdata < NULL_LINK)) begin
                  oldest <= nxt_rdata;
                end
                if (!(nxt_rdata < NULL_LINK)) begin
                  newest <= prv_rdata;
                end
                if (op_q == lrq_pkg::OP_ERASE) begin
                  present[idx_q] <= 1'b0;
                  entry_count    <= count_dec;
                  pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_OK, last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  state <= S_APP_A;
                end
              end
            end
            default: begin
              pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_OK, last: 1'b1};
              state <= S_EMIT;
            end
          endcase
        end
        S_APP_A: begin
          state <= S_APP_B;
        end
        S_APP_B: begin
          // append as newest
          if (!(newest < NULL_LINK)) begin
            oldest <= idx_link;
          end
          newest <= idx_link;
          if (op_q == lrq_pkg::OP_INSERT) begin
            state <= S_EV_RD;
          end else begin
            pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_OK, last: 1'b1};
            state <= S_EMIT;
          end
        end
        S_EV_RD: begin
          if (evict_cond) begin
            victim <= oldest[IW-1:0];
            state  <= S_EV_WR;
          end else begin
            pend  <= '{id: '0, evict: 1'b0, status: lrq_pkg::ST_OK, last: 1'b1};
            state <= S_EMIT;
          end
        end
        S_EV_WR: begin
          // drop the oldest entry
          oldest <= nxt_rdata;
          if (!(nxt_rdata < NULL_LINK)) begin
            newest <= NULL_LINK;
          end
          present[victim] <= 1'b0;
          entry_count     <= count_dec;
          pend  <= '{id: lrq_pkg::ID_W'(victim), evict: 1'b1, status: lrq_pkg::ST_OK,
                     last: last_calc};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_q     <= pend;
            state     <= pend.last ? S_IDLE : S_EV_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/lrq_checker.sv]
// port-level checks on the result channel
module lrq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [lrq_pkg::ID_W-1:0]        res_evicted_id,
  input logic                            res_evict_valid,
  input logic [lrq_pkg::ST_W-1:0]        res_status,
  input logic                            res_last
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_evicted_id) &&
      $stable(res_evict_valid) && $stable(res_status) && $stable(res_last))
    else $error("result changed while stalled");

  // evictions always carry an ok status
  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_evict_valid |-> res_status == lrq_pkg::ST_OK)
    else $error("eviction with error status");

  // no eviction means no slot number and the last flag set
  a_no_evict_id: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_evict_valid |-> res_evicted_id == '0 && res_last)
    else $error("non-eviction result with slot or without last");

  // error results are single, final transfers
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != lrq_pkg::ST_OK) |-> res_last && !res_evict_valid)
    else $error("error result not final");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind lru_replacement_queue lrq_checker u_lrq_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_evicted_id  (res.evicted_id),
  .res_evict_valid (res.evict_valid),
  .res_status      (res.status),
  .res_last        (res.last)
);

[tb/tb_lru_replacement_queue.sv]
`timescale 1ns / 1ps

module tb_lru_replacement_queue;

  localparam int SLOTS        = 64;
  localparam logic [lrq_pkg::LIMIT_W-1:0] NO_LINK = 7'd64;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_TOP    = 127;

  // register map: word 0 holds the limit, word 1 has no register behind it
  localparam logic [lrq_pkg::APB_ADDR_W-1:0] ADDR_LIMIT  =
    {lrq_pkg::REG_CAPACITY_LIMIT, 2'b00};
  localparam logic [lrq_pkg::APB_ADDR_W-1:0] ADDR_UNUSED =
    {~lrq_pkg::REG_CAPACITY_LIMIT, 2'b00};

  typedef struct packed {
    logic [lrq_pkg::ID_W-1:0] evicted_id;
    logic                     evict_valid;
    logic [lrq_pkg::ST_W-1:0] status;
    logic                     last;
  } lru_result_t;

  // LRU list predictor plus the queue of results it still owes
  class lru_scoreboard;
    logic [lrq_pkg::LIMIT_W-1:0] next_of [SLOTS];
    logic [lrq_pkg::LIMIT_W-1:0] prev_of [SLOTS];
    bit                          in_list [SLOTS];
    logic [lrq_pkg::LIMIT_W-1:0] oldest_slot;
    logic [lrq_pkg::LIMIT_W-1:0] newest_slot;
    int                          live_count;
    logic [lrq_pkg::LIMIT_W-1:0] limit;
    lru_result_t                 expected_q[$];
    int                          mismatches;
    int                          requests;
    int                          results;
    int                          evictions;
    int                          worst_burst;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        next_of[i] = NO_LINK;
        prev_of[i] = NO_LINK;
        in_list[i] = 1'b0;
      end
      oldest_slot = NO_LINK;
      newest_slot = NO_LINK;
      live_count  = 0;
      limit       = lrq_pkg::LIMIT_RESET;
      mismatches  = 0;
      requests    = 0;
      results     = 0;
      evictions   = 0;
      worst_burst = 0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    function void unlink(logic [lrq_pkg::ID_W-1:0] slot);
      logic [lrq_pkg::LIMIT_W-1:0] p;
      logic [lrq_pkg::LIMIT_W-1:0] n;
      p = prev_of[slot];
      n = next_of[slot];
      if (p != NO_LINK) next_of[p[lrq_pkg::ID_W-1:0]] = n;
      else oldest_slot = n;
      if (n != NO_LINK) prev_of[n[lrq_pkg::ID_W-1:0]] = p;
      else newest_slot = p;
    endfunction

    function void append(logic [lrq_pkg::ID_W-1:0] slot);
      prev_of[slot] = newest_slot;
      next_of[slot] = NO_LINK;
      if (newest_slot != NO_LINK)
        next_of[newest_slot[lrq_pkg::ID_W-1:0]] = lrq_pkg::LIMIT_W'(slot);
      else oldest_slot = lrq_pkg::LIMIT_W'(slot);
      newest_slot = lrq_pkg::LIMIT_W'(slot);
    endfunction

    function void expect_result(int id, bit ev, logic [lrq_pkg::ST_W-1:0] st, bit lst);
      lru_result_t r;
      r.evicted_id  = lrq_pkg::ID_W'(id);
      r.evict_valid = ev;
      r.status      = st;
      r.last        = lst;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // update the list for one accepted request and queue what it yields
    function void apply_request(logic [lrq_pkg::OP_W-1:0] op, logic [lrq_pkg::ID_W-1:0] id);
      int                       burst;
      logic [lrq_pkg::ID_W-1:0] victim;
      requests++;
      if (op == lrq_pkg::OP_NONE) begin
        expect_result(0, 1'b0, lrq_pkg::ST_OK, 1'b1);
      end else if (op == lrq_pkg::OP_INSERT && in_list[id]) begin
        expect_result(0, 1'b0, lrq_pkg::ST_DUP, 1'b1);
      end else if (op == lrq_pkg::OP_INSERT) begin
        in_list[id] = 1'b1;
        append(id);
        live_count++;
        // the list holds exactly live_count slots, so the burst is known up front
        burst = (live_count > int'(limit)) ? live_count - int'(limit) : 0;
        for (int k = 0; k < burst; k++) begin
          victim = oldest_slot[lrq_pkg::ID_W-1:0];
          unlink(victim);
          in_list[victim] = 1'b0;
          live_count--;
          expect_result(victim, 1'b1, lrq_pkg::ST_OK, k == burst - 1);
        end
        if (burst == 0) expect_result(0, 1'b0, lrq_pkg::ST_OK, 1'b1);
        evictions += burst;
        if (burst > worst_burst) worst_burst = burst;
      end else if (!in_list[id]) begin
        expect_result(0, 1'b0, lrq_pkg::ST_ABSENT, 1'b1);
      end else begin
        unlink(id);
        if (op == lrq_pkg::OP_TOUCH) begin
          append(id);
        end else begin
          in_list[id] = 1'b0;
          live_count--;
        end
        expect_result(0, 1'b0, lrq_pkg::ST_OK, 1'b1);
      end
    endfunction

    function void check_result(lru_result_t got);
      lru_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result id=%0d ev=%0b st=%0d last=%0b",
                         got.evicted_id, got.evict_valid, got.status, got.last));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if (got.evicted_id !== want.evicted_id || got.evict_valid !== want.evict_valid ||
          got.status !== want.status || got.last !== want.last)
        report($sformatf("result %0d: expected id=%0d ev=%0b st=%0d last=%0b, %s",
                         results, want.evicted_id, want.evict_valid, want.status,
                         want.last,
                         $sformatf("got id=%0d ev=%0b st=%0d last=%0b", got.evicted_id,
                                   got.evict_valid, got.status, got.last)));
    endfunction

    // random slot that is (or is not) on the list, -1 if there is none
    function int pick_slot(bit want_present);
      int hits;
      int choice;
      hits = 0;
      for (int i = 0; i < SLOTS; i++) if (in_list[i] == want_present) hits++;
      if (hits == 0) return -1;
      choice = $urandom_range(hits - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (in_list[i] == want_present) begin
          if (choice == 0) return i;
          choice--;
        end
      end
      return -1;
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lrq_pkg::APB_ADDR_W-1:0] paddr;
  logic [lrq_pkg::APB_DATA_W-1:0] pwdata;
  logic [lrq_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  lrq_req_if req_ch ();
  lrq_res_if res_ch ();

  lru_scoreboard sb;
  int            idle_pct;
  int            stall_pct;
  int            hold_request;
  int            hold_left;
  int            cycle_count;
  int            limit_writes;

  lru_replacement_queue dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side ready: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = (int'($urandom_range(99)) >= stall_pct);
    end
  end

  // check every result transfer
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(lru_result_t'({res_ch.evicted_id, res_ch.evict_valid,
                                     res_ch.status, res_ch.last}));
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL lru_replacement_queue");
      $finish;
    end
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_op(logic [lrq_pkg::OP_W-1:0] op, logic [lrq_pkg::ID_W-1:0] id);
    @(negedge clk);
    while (int'($urandom_range(99)) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = op;
    req_ch.entry_id  = id;
    do @(posedge clk); while (!req_ch.ready);
    sb.apply_request(op, id);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_idle();
    @(negedge clk) req_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [lrq_pkg::APB_ADDR_W-1:0] addr,
                           logic [lrq_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LIMIT) sb.limit = data[lrq_pkg::LIMIT_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_check_limit();
    logic [lrq_pkg::APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_LIMIT;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== lrq_pkg::APB_DATA_W'(sb.limit))
      sb.report($sformatf("limit read back: expected %0d, got %0d", sb.limit, got));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // new limit once the block is idle; upper data bits are junk on purpose
  task automatic set_limit(int lim);
    logic [lrq_pkg::APB_DATA_W-1:0] data;
    wait_idle();
    data                            = $urandom();
    data[lrq_pkg::LIMIT_W-1:0]      = lrq_pkg::LIMIT_W'(lim);
    apb_write(ADDR_LIMIT, data);
    limit_writes++;
    apb_check_limit();
  endtask

  // mostly well-formed requests, some aimed at the wrong slots, a few unused opcodes
  task automatic run_random(int items, int idle, int stall, int insert_pct);
    int                       sent;
    logic [lrq_pkg::OP_W-1:0] op;
    int                       slot;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 5) begin
        send_op(lrq_pkg::OP_NONE, lrq_pkg::ID_W'($urandom_range(SLOTS - 1)));
      end else begin
        if (int'($urandom_range(99)) < insert_pct) op = lrq_pkg::OP_INSERT;
        else if ($urandom_range(99) < 60) op = lrq_pkg::OP_TOUCH;
        else op = lrq_pkg::OP_ERASE;
        slot = -1;
        if ($urandom_range(99) < 85) slot = sb.pick_slot(op != lrq_pkg::OP_INSERT);
        if (slot < 0) slot = $urandom_range(SLOTS - 1);
        send_op(op, lrq_pkg::ID_W'(slot));
      end
      sent++;
    end
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = lrq_pkg::OP_INSERT;
    req_ch.entry_id  = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_request     = 0;
    hold_left        = 0;
    cycle_count      = 0;
    limit_writes     = 0;
    sb               = new();
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: rejects, unused opcode, duplicates, touch order, id extremes
    apb_check_limit();
    send_op(lrq_pkg::OP_TOUCH, 6'd5);
    send_op(lrq_pkg::OP_ERASE, 6'd63);
    send_op(lrq_pkg::OP_NONE, 6'd63);
    send_op(lrq_pkg::OP_INSERT, 6'd0);
    send_op(lrq_pkg::OP_INSERT, 6'd63);
    send_op(lrq_pkg::OP_INSERT, 6'd42);
    send_op(lrq_pkg::OP_INSERT, 6'd21);
    send_op(lrq_pkg::OP_INSERT, 6'd0);
    send_op(lrq_pkg::OP_TOUCH, 6'd0);
    send_op(lrq_pkg::OP_ERASE, 6'd63);
    send_op(lrq_pkg::OP_ERASE, 6'd63);

    // lowered limit waits for the next insert, which then evicts two
    set_limit(2);
    send_op(lrq_pkg::OP_TOUCH, 6'd42);
    send_op(lrq_pkg::OP_INSERT, 6'd7);

    // zero limit: insert evicts everything, the new slot too; spare word ignored
    set_limit(0);
    apb_write(ADDR_UNUSED, 32'h0000_0011);
    apb_check_limit();
    send_op(lrq_pkg::OP_INSERT, 6'd1);
    send_op(lrq_pkg::OP_INSERT, 6'd2);
    send_op(lrq_pkg::OP_TOUCH, 6'd2);

    // limit above the slot count never evicts
    set_limit(LIMIT_TOP);
    send_op(lrq_pkg::OP_INSERT, 6'd3);
    send_op(lrq_pkg::OP_INSERT, 6'd4);
    send_op(lrq_pkg::OP_ERASE, 6'd3);
    send_op(lrq_pkg::OP_TOUCH, 6'd4);
    send_op(lrq_pkg::OP_NONE, 6'd0);

    // random phases with different handshake mixes and limits
    set_limit(int'(lrq_pkg::LIMIT_RESET));
    run_random(45, 0, 0, 45);
    set_limit(8);
    run_random(40, 81, 0, 50);
    set_limit(2);
    run_random(40, 0, 81, 50);
    set_limit(LIMIT_TOP);
    run_random(40, 23, 23, 85);

    // big eviction burst while the result side is held off; input must back up
    set_limit(1);
    hold_request = HOLD_CYCLES;
    run_random(25, 0, 0, 50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

    $display("covered %0d requests, %0d result transfers, %0d evictions (largest burst %0d)",
             sb.requests, sb.results, sb.evictions, sb.worst_burst);
    $display("across %0d limit settings, four idle/stall mixes and a long result hold-off",
             limit_writes);
    if (sb.mismatches == 0) begin
      $display("PASS lru_replacement_queue");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL lru_replacement_queue");
    end
    $finish;
  end

endmodule
